>>> rtl/misf_pkg.sv
// ----------------------------------------------------------------------------
// misf_pkg: shared types and constants for manual input source fusion
// Command and frame words, configuration register indexes and fixed codes.
// ----------------------------------------------------------------------------
package misf_pkg;

    localparam int SRC_W  = 4;
    localparam int LANE_W = 16;
    localparam int LANES  = 8;   // five channels then three mouse axes
    localparam int CH_LANES = 5;
    localparam int ERR_LANES = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0]  SW_DOWN     = 8'd2;
    localparam logic [7:0]  SW_UP       = 8'd1;
    localparam logic [7:0]  SW_MID      = 8'd3;
    localparam logic [15:0] SW_NEUTRAL  = {SW_DOWN, SW_DOWN};
    localparam logic [14:0] ERR_LIMIT_RESET = 15'd724;

    typedef enum logic {
        CMD_STORE   = 1'b0,
        CMD_REFRESH = 1'b1
    } misf_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIX_MODE   = 3'd0,
        CFG_PREF_SRC   = 3'd1,
        CFG_TIMEOUT    = 3'd2,
        CFG_BOARD_MASK = 3'd3,
        CFG_ERR_LIMIT  = 3'd4
    } misf_cfg_idx_t;

    typedef struct packed {
        logic               command;
        logic [SRC_W-1:0]   source;
        logic [31:0]        cur_tick;
        logic [63:0]        chan_lo;
        logic signed [15:0] chan_four;
        logic [15:0]        switch_pair;
        logic [47:0]        mouse_xyz;
        logic [15:0]        button_pair;
        logic [15:0]        key_bits;
        logic               board_key_down;
    } misf_in_t;

    typedef struct packed {
        logic [SRC_W-1:0]   fused_source;
        logic [63:0]        out_chan_lo;
        logic signed [15:0] out_chan_four;
        logic [15:0]        out_switches;
        logic [47:0]        out_mouse;
        logic [15:0]        out_buttons;
        logic [15:0]        out_keys;
        logic               data_error;
        logic               source_changed;
    } misf_out_t;

    typedef struct packed {
        logic [LANES-1:0][LANE_W-1:0] lane;
        logic [15:0]                  sw;
        logic [15:0]                  buttons;
        logic [15:0]                  keys;
        logic [31:0]                  stamp;
    } misf_snap_t;

endpackage

>>> rtl/manual_input_source_fusion.sv
// ----------------------------------------------------------------------------
// manual_input_source_fusion
// Per-source input snapshots fused into one frame by a small sequencer.
// ----------------------------------------------------------------------------
// Each store or refresh word produces one fused frame; a store to source 0 or
// above SOURCE_COUNT is dropped in its accept cycle with no frame. Otherwise
// one shared age/compare datapath walks the snapshot registers, one source per
// cycle: a scan over all N sources (N = SOURCE_COUNT) finds the active ones
// and the newest, a pick step chooses, then a magnitude merge over all N
// sources in merge mode or a single load in select mode, then the frame
// register is written, which waits while frame_stall holds the frame before.
// The merge or load is skipped when nothing is active. cmd_stall is high
// while a word is in progress.
// ----------------------------------------------------------------------------
module manual_input_source_fusion
    import misf_pkg::*;
#(
    parameter int SOURCE_COUNT = 4
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  misf_in_t              cmd_word,
    output logic                  frame_valid,
    input  logic                  frame_stall,
    output misf_out_t             frame_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SOURCE_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LATEST,
        S_PICK,
        S_MERGE,
        S_SELECT,
        S_FINISH
    } state_t;

    function automatic logic [LANE_W-1:0] mag(input logic [LANE_W-1:0] v);
        return v[LANE_W-1] ? LANE_W'(~v + 1'b1) : v;
    endfunction

    function automatic logic [15:0] sanitize(input logic [15:0] sw);
        logic [15:0] r;
        logic [7:0]  b;
        r = '0;
        for (int i = 0; i < 2; i++)
        begin
            b = sw[8*i +: 8];
            if (b != SW_UP && b != SW_DOWN && b != SW_MID)
                b = SW_DOWN;
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

    function automatic misf_snap_t pack_snap(input misf_in_t c);
        misf_snap_t s;
        for (int k = 0; k < ERR_LANES; k++)
            s.lane[k] = c.chan_lo[16*k +: 16];
        s.lane[ERR_LANES] = c.chan_four;
        for (int k = 0; k < 3; k++)
            s.lane[CH_LANES + k] = c.mouse_xyz[16*k +: 16];
        s.sw      = c.switch_pair;
        s.buttons = c.button_pair;
        s.keys    = c.key_bits;
        s.stamp   = c.cur_tick;
        return s;
    endfunction

    // configuration
    logic        mix_mode_reg;
    logic [3:0]  pref_reg;
    logic [31:0] timeout_reg;
    logic [15:0] board_mask_reg;
    logic [14:0] err_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_mode_reg   <= 1'b0;
            pref_reg       <= '0;
            timeout_reg    <= '0;
            board_mask_reg <= '0;
            err_limit_reg  <= ERR_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIX_MODE:   mix_mode_reg   <= cfg_data[0];
                CFG_PREF_SRC:   pref_reg       <= cfg_data[3:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                CFG_BOARD_MASK: board_mask_reg <= cfg_data[15:0];
                CFG_ERR_LIMIT:  err_limit_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // snapshots
    misf_snap_t snap_reg [SOURCE_COUNT];
    logic       cmd_acc;
    logic       store_ok;
    logic       go;

    assign cmd_acc  = cmd_valid && !cmd_stall;
    assign store_ok = (cmd_word.command == CMD_STORE) && (cmd_word.source != '0)
                      && (cmd_word.source <= SRC_W'(SOURCE_COUNT));
    assign go       = cmd_acc && (cmd_word.command == CMD_REFRESH || store_ok);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SOURCE_COUNT; i++)
        begin
            if (cmd_acc && store_ok && cmd_word.source == SRC_W'(i + 1))
                snap_reg[i] <= pack_snap(cmd_word);
        end
    end

    // sequencer state
    state_t                       state_reg,      state_next;
    logic [IDX_W-1:0]             idx_reg,        idx_next;
    logic [31:0]                  now_reg,        now_next;
    logic                         bkd_reg,        bkd_next;
    logic [SOURCE_COUNT-1:0]      snap_valid_reg, snap_valid_next;
    logic [SOURCE_COUNT-1:0]      act_reg,        act_next;
    logic                         found_reg,      found_next;
    logic [IDX_W-1:0]             best_idx_reg,   best_idx_next;
    logic [31:0]                  newest_age_reg, newest_age_next;
    logic [SRC_W-1:0]             chosen_reg,     chosen_next;
    logic [SRC_W-1:0]             last_reg,       last_next;
    logic [LANES-1:0][LANE_W-1:0] acc_lane_reg,   acc_lane_next;
    logic [15:0]                  acc_sw_reg,     acc_sw_next;
    logic [15:0]                  acc_btn_reg,    acc_btn_next;
    logic [15:0]                  acc_key_reg,    acc_key_next;
    logic                         fvalid_reg,     fvalid_next;
    misf_out_t                    fword_reg,      fword_next;

    // shared datapath
    misf_snap_t       rd;
    logic [31:0]      age;
    logic             rd_active;
    logic             newer;
    logic [SRC_W-1:0] latest;
    logic             pref_hit;
    misf_out_t        built;

    always_comb
    begin
        rd        = snap_reg[idx_reg];
        age       = now_reg - rd.stamp;
        rd_active = snap_valid_reg[idx_reg]
                    && (timeout_reg == '0 || age <= timeout_reg);
        newer     = rd_active && (!found_reg || age < newest_age_reg);
        latest    = found_reg ? SRC_W'(best_idx_reg) + 1'b1 : '0;
        pref_hit  = 1'b0;
        for (int s = 0; s < SOURCE_COUNT; s++)
        begin
            if (pref_reg == SRC_W'(s + 1) && act_reg[s])
                pref_hit = 1'b1;
        end
    end

    always_comb
    begin
        built.fused_source   = chosen_reg;
        built.out_chan_lo    = {acc_lane_reg[3], acc_lane_reg[2],
                                acc_lane_reg[1], acc_lane_reg[0]};
        built.out_chan_four  = acc_lane_reg[ERR_LANES];
        built.out_switches   = acc_sw_reg;
        built.out_mouse      = {acc_lane_reg[7], acc_lane_reg[6], acc_lane_reg[5]};
        built.out_buttons    = acc_btn_reg;
        built.out_keys       = acc_key_reg | (bkd_reg ? board_mask_reg : 16'h0000);
        built.data_error     = (acc_sw_reg[7:0] == '0) || (acc_sw_reg[15:8] == '0);
        for (int k = 0; k < ERR_LANES; k++)
        begin
            if (mag(acc_lane_reg[k]) > {1'b0, err_limit_reg})
                built.data_error = 1'b1;
        end
        built.source_changed = (chosen_reg != last_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        bkd_next        = bkd_reg;
        snap_valid_next = snap_valid_reg;
        act_next        = act_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        newest_age_next = newest_age_reg;
        chosen_next     = chosen_reg;
        last_next       = last_reg;
        acc_lane_next   = acc_lane_reg;
        acc_sw_next     = acc_sw_reg;
        acc_btn_next    = acc_btn_reg;
        acc_key_next    = acc_key_reg;
        fvalid_next     = fvalid_reg && frame_stall;
        fword_next      = fword_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    for (int i = 0; i < SOURCE_COUNT; i++)
                    begin
                        if (store_ok && cmd_word.source == SRC_W'(i + 1))
                            snap_valid_next[i] = 1'b1;
                    end
                    now_next      = cmd_word.cur_tick;
                    bkd_next      = cmd_word.board_key_down;
                    idx_next      = '0;
                    found_next    = 1'b0;
                    act_next      = '0;
                    acc_lane_next = '0;
                    acc_sw_next   = SW_NEUTRAL;
                    acc_btn_next  = '0;
                    acc_key_next  = '0;
                    state_next    = S_LATEST;
                end
            end
            S_LATEST:
            begin
                act_next[idx_reg] = rd_active;
                if (newer)
                begin
                    found_next      = 1'b1;
                    newest_age_next = age;
                    best_idx_next   = idx_reg;
                end
                if (idx_reg == LAST_IDX)
                    state_next = S_PICK;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_PICK:
            begin
                if (mix_mode_reg)
                begin
                    chosen_next = latest;
                    idx_next    = '0;
                    state_next  = found_reg ? S_MERGE : S_FINISH;
                end
                else if (pref_hit)
                begin
                    chosen_next = pref_reg;
                    idx_next    = IDX_W'(pref_reg - 1'b1);
                    state_next  = S_SELECT;
                end
                else
                begin
                    chosen_next = latest;
                    idx_next    = best_idx_reg;
                    state_next  = found_reg ? S_SELECT : S_FINISH;
                end
            end
            S_MERGE:
            begin
                if (act_reg[idx_reg])
                begin
                    for (int k = 0; k < LANES; k++)
                    begin
                        if (mag(rd.lane[k]) > mag(acc_lane_reg[k]))
                            acc_lane_next[k] = rd.lane[k];
                    end
                    acc_btn_next = acc_btn_reg | rd.buttons;
                    acc_key_next = acc_key_reg | rd.keys;
                end
                if (idx_reg == best_idx_reg)
                    acc_sw_next = sanitize(rd.sw);
                if (idx_reg == LAST_IDX)
                    state_next = S_FINISH;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_SELECT:
            begin
                acc_lane_next = rd.lane;
                acc_sw_next   = sanitize(rd.sw);
                acc_btn_next  = rd.buttons;
                acc_key_next  = rd.keys;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (!fvalid_reg || !frame_stall)
                begin
                    fvalid_next = 1'b1;
                    fword_next  = built;
                    last_next   = chosen_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            snap_valid_reg <= '0;
            last_reg       <= '0;
            fvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            snap_valid_reg <= snap_valid_next;
            last_reg       <= last_next;
            fvalid_reg     <= fvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        now_reg        <= now_next;
        bkd_reg        <= bkd_next;
        act_reg        <= act_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        newest_age_reg <= newest_age_next;
        chosen_reg     <= chosen_next;
        acc_lane_reg   <= acc_lane_next;
        acc_sw_reg     <= acc_sw_next;
        acc_btn_reg    <= acc_btn_next;
        acc_key_reg    <= acc_key_next;
        fword_reg      <= fword_next;
    end

    assign cmd_stall   = (state_reg != S_IDLE);
    assign frame_valid = fvalid_reg;
    assign frame_word  = fword_reg;

endmodule

>>> rtl/misf_checker.sv
// ----------------------------------------------------------------------------
// misf_checker: port-level checks for manual input source fusion
// Watches the frame channel of the top level; bound in below.
// ----------------------------------------------------------------------------
module misf_checker
    import misf_pkg::*;
#(
    parameter int SOURCE_COUNT = 4
)(
    input logic      clk,
    input logic      rst_n,
    input logic      frame_valid,
    input logic      frame_stall,
    input misf_out_t frame_word
);

    // a held word must not move
    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_stall |=> frame_valid && $stable(frame_word))
        else $error("frame word changed while stalled");

    a_source_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> frame_word.fused_source <= SRC_W'(SOURCE_COUNT))
        else $error("active source out of range");

    a_switch_sane: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |->
            (frame_word.out_switches[7:0] == SW_UP
             || frame_word.out_switches[7:0] == SW_DOWN
             || frame_word.out_switches[7:0] == SW_MID)
            && (frame_word.out_switches[15:8] == SW_UP
             || frame_word.out_switches[15:8] == SW_DOWN
             || frame_word.out_switches[15:8] == SW_MID))
        else $error("unsanitised switch byte");

    // nothing active: neutral frame, keys may carry the board mask only
    a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_word.fused_source == '0 |->
            frame_word.out_chan_lo == '0 && frame_word.out_chan_four == '0
            && frame_word.out_mouse == '0 && frame_word.out_buttons == '0
            && frame_word.out_switches == SW_NEUTRAL && !frame_word.data_error)
        else $error("frame not neutral with no active source");

endmodule

bind manual_input_source_fusion misf_checker #(
    .SOURCE_COUNT(SOURCE_COUNT)
) u_misf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_word  (frame_word)
);

>>> tb/sv/tb_manual_input_source_fusion.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// tb_manual_input_source_fusion: self-checking bench for source fusion
// Store and refresh words are sent in bursts. A bench-side model keeps its own
// copy of the snapshots and registers and predicts every frame. Each frame is
// compared field by field. A directed table comes first. Randomised phases
// follow, each under new register settings. The frame side stalls
// irregularly, and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_manual_input_source_fusion;
    import misf_pkg::*;

    localparam int NSRC          = 4;
    localparam int SETTLE_CYCLES = 2 * NSRC + 8;
    localparam int PHASES        = 12;
    localparam int PHASE_FRAMES  = 152;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [63:0] CH_MIN = {4{16'h8000}};
    localparam logic [63:0] CH_MAX = {4{16'h7fff}};
    localparam logic [47:0] MS_MIN = {3{16'h8000}};
    localparam logic [47:0] MS_MAX = {3{16'h7fff}};
    localparam misf_out_t NO_FRAME = '0;

    typedef enum int {ROW_PREDICT, ROW_FIXED, ROW_DROPPED, ROW_REG} row_kind_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        row_kind_t     kind;
        misf_in_t      word;
        misf_out_t     frame;
        misf_cfg_idx_t reg_idx;
        logic [31:0]   reg_val;
    } drill_row_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cmd_valid   = 1'b0;
    logic                  cmd_stall;
    misf_in_t              cmd_word    = '0;
    logic                  frame_valid;
    logic                  frame_stall = 1'b0;
    misf_out_t             frame_word;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    manual_input_source_fusion #(
        .SOURCE_COUNT(NSRC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_word(cmd_word),
        .frame_valid(frame_valid),
        .frame_stall(frame_stall),
        .frame_word(frame_word),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // bench copy of snapshots and registers
    misf_snap_t  snap      [NSRC];
    bit          snap_held [NSRC];
    logic [3:0]  last_source;
    bit          cfg_mix;
    logic [3:0]  cfg_pref;
    logic [31:0] cfg_timeout;
    logic [15:0] cfg_mask;
    logic [14:0] cfg_limit;

    misf_out_t   frames_due [$];
    drill_row_t  drill [$];
    int          mismatches     = 0;
    int          frames_checked = 0;
    int          words_sent     = 0;
    int          words_dropped  = 0;
    int          burst_left     = 0;
    logic [31:0] tick_now       = 32'd6000;
    bit          hold_phase     = 1'b0;

    int          hold_cnt   = 0;
    int          mode_left  = 0;
    bit          hold_done  = 1'b0;
    stall_mode_t stall_mode = STALL_NONE;

    function automatic logic [16:0] mag(input logic [15:0] v);
        return v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
    endfunction

    function automatic bit is_live(input int s, input logic [31:0] now);
        logic [31:0] age;
        if (s < 1 || s > NSRC)
            return 1'b0;
        if (!snap_held[s-1])
            return 1'b0;
        age = now - snap[s-1].stamp;
        return (cfg_timeout == 32'd0) || (age <= cfg_timeout);
    endfunction

    function automatic logic [15:0] clean_switches(input logic [15:0] sw);
        logic [15:0] r;
        logic [7:0]  b;
        for (int i = 0; i < 2; i++)
        begin
            b = sw[8*i +: 8];
            if (b < SW_UP || b > SW_MID)
                b = SW_DOWN;
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

    // Applies one word to the bench state; returns 1 when a frame is due.
    function automatic bit fuse_frame(input misf_in_t w, output misf_out_t f);
        logic [LANES-1:0][LANE_W-1:0] ln;
        logic [15:0] sw;
        logic [15:0] btn;
        logic [15:0] keys;
        logic [31:0] age;
        logic [31:0] newest_age;
        int          slot;
        int          latest;
        int          chosen;
        bit          err;
        f = '0;
        if (w.command == CMD_STORE)
        begin
            if (w.source == 4'd0 || w.source > NSRC)
                return 1'b0;
            slot = w.source - 1;
            snap[slot].lane    = {w.mouse_xyz, w.chan_four, w.chan_lo};
            snap[slot].sw      = w.switch_pair;
            snap[slot].buttons = w.button_pair;
            snap[slot].keys    = w.key_bits;
            snap[slot].stamp   = w.cur_tick;
            snap_held[slot]    = 1'b1;
        end

        latest     = 0;
        newest_age = '0;
        for (int s = 1; s <= NSRC; s++)
        begin
            if (is_live(s, w.cur_tick))
            begin
                age = w.cur_tick - snap[s-1].stamp;
                if (latest == 0 || age < newest_age)
                begin
                    latest     = s;
                    newest_age = age;
                end
            end
        end

        ln   = '0;
        sw   = SW_NEUTRAL;
        btn  = '0;
        keys = '0;
        if (cfg_mix)
        begin
            chosen = latest;
            if (latest != 0)
            begin
                sw = clean_switches(snap[latest-1].sw);
                for (int s = 1; s <= NSRC; s++)
                begin
                    if (is_live(s, w.cur_tick))
                    begin
                        for (int k = 0; k < LANES; k++)
                            if (mag(snap[s-1].lane[k]) > mag(ln[k]))
                                ln[k] = snap[s-1].lane[k];
                        btn  = btn | snap[s-1].buttons;
                        keys = keys | snap[s-1].keys;
                    end
                end
            end
        end
        else
        begin
            chosen = cfg_pref;
            if (chosen == 0 || !is_live(chosen, w.cur_tick))
                chosen = latest;
            if (chosen != 0)
            begin
                ln   = snap[chosen-1].lane;
                sw   = clean_switches(snap[chosen-1].sw);
                btn  = snap[chosen-1].buttons;
                keys = snap[chosen-1].keys;
            end
        end

        if (cfg_mask != 16'd0 && w.board_key_down)
            keys = keys | cfg_mask;

        err = (sw[7:0] == 8'd0) || (sw[15:8] == 8'd0);
        for (int k = 0; k < ERR_LANES; k++)
            if (mag(ln[k]) > cfg_limit)
                err = 1'b1;

        f.fused_source   = 4'(chosen);
        f.out_chan_lo    = ln[3:0];
        f.out_chan_four  = ln[4];
        f.out_switches   = sw;
        f.out_mouse      = ln[7:5];
        f.out_buttons    = btn;
        f.out_keys       = keys;
        f.data_error     = err;
        f.source_changed = (4'(chosen) != last_source);
        last_source      = 4'(chosen);
        return 1'b1;
    endfunction

    function automatic void add_word(input row_kind_t kind, input misf_in_t word,
                                     input misf_out_t frame);
        drill_row_t r;
        r.kind    = kind;
        r.word    = word;
        r.frame   = frame;
        r.reg_idx = CFG_MIX_MODE;
        r.reg_val = '0;
        drill.push_back(r);
    endfunction

    function automatic void add_reg(input misf_cfg_idx_t idx, input logic [31:0] val);
        drill_row_t r;
        r.kind    = ROW_REG;
        r.word    = '0;
        r.frame   = NO_FRAME;
        r.reg_idx = idx;
        r.reg_val = val;
        drill.push_back(r);
    endfunction

    function automatic logic [15:0] pick_lane();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            2: v = 16'h0000;
            3: v = 16'hffff;
            4:
            begin
                // just around the error limit, either sign
                v = {1'b0, cfg_limit} + 16'($urandom_range(0, 2)) - 16'd1;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_switch();
        int k;
        k = $urandom_range(0, 5);
        return (k < 4) ? 8'(k) : 8'($urandom);
    endfunction

    function automatic misf_in_t random_word();
        misf_in_t w;
        case ($urandom_range(0, 15))
            0:       tick_now = $urandom;
            1, 2:    tick_now = tick_now - $urandom_range(1, 30);
            default: tick_now = tick_now + $urandom_range(0, 40);
        endcase
        w.command        = ($urandom_range(0, 3) == 0) ? CMD_REFRESH : CMD_STORE;
        w.source         = ($urandom_range(0, 11) == 0) ? 4'($urandom)
                                                        : 4'($urandom_range(1, NSRC));
        w.cur_tick       = tick_now;
        w.chan_lo        = {pick_lane(), pick_lane(), pick_lane(), pick_lane()};
        w.chan_four      = pick_lane();
        w.switch_pair    = {pick_switch(), pick_switch()};
        w.mouse_xyz      = {pick_lane(), pick_lane(), pick_lane()};
        w.button_pair    = 16'($urandom);
        w.key_bits       = 16'($urandom);
        w.board_key_down = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    task automatic send_word(input misf_in_t w, input row_kind_t kind,
                             input misf_out_t fixed, output bit produced);
        misf_out_t f;
        int        gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_word  <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        produced = fuse_frame(w, f);
        words_sent++;
        if (!produced)
            words_dropped++;
        if (kind == ROW_FIXED)
            frames_due.push_back(fixed);
        else if (kind == ROW_PREDICT && produced)
            frames_due.push_back(f);
    endtask

    task automatic settle();
        cmd_valid  <= 1'b0;
        burst_left = 0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input misf_cfg_idx_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MIX_MODE:   cfg_mix     = val[0];
            CFG_PREF_SRC:   cfg_pref    = val[3:0];
            CFG_TIMEOUT:    cfg_timeout = val;
            CFG_BOARD_MASK: cfg_mask    = val[15:0];
            CFG_ERR_LIMIT:  cfg_limit   = val[14:0];
            default: ;
        endcase
    endtask

    // frame side: own stall pattern, plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
        begin
            hold_cnt    <= hold_cnt - 1;
            frame_stall <= 1'b1;
        end
        else if (hold_phase && !hold_done)
        begin
            hold_done   <= 1'b1;
            hold_cnt    <= HOLD_CYCLES;
            frame_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(16, 128);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  frame_stall <= 1'b0;
                STALL_LIGHT: frame_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: frame_stall <= ($urandom_range(0, 3) != 0);
                default:     frame_stall <= (mode_left[2:0] != 3'd0);
            endcase
        end
    end

    always @(posedge clk)
    begin : frame_check
        misf_out_t want;
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (frames_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: frame expected none got %h", $time, frame_word);
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("fused_source", want.fused_source, frame_word.fused_source);
                check_field("out_chan_lo", want.out_chan_lo, frame_word.out_chan_lo);
                check_field("out_chan_four", want.out_chan_four, frame_word.out_chan_four);
                check_field("out_switches", want.out_switches, frame_word.out_switches);
                check_field("out_mouse", want.out_mouse, frame_word.out_mouse);
                check_field("out_buttons", want.out_buttons, frame_word.out_buttons);
                check_field("out_keys", want.out_keys, frame_word.out_keys);
                check_field("data_error", want.data_error, frame_word.data_error);
                check_field("source_changed", want.source_changed,
                            frame_word.source_changed);
                frames_checked++;
            end
        end
    end

    initial
    begin
        #(10_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        bit          produced;
        int          made;
        logic [31:0] tmo;
        logic [31:0] mask;
        logic [31:0] lim;

        for (int i = 0; i < NSRC; i++)
        begin
            snap[i]      = '0;
            snap[i].sw   = SW_NEUTRAL;
            snap_held[i] = 1'b0;
        end
        last_source = '0;
        cfg_mix     = 1'b0;
        cfg_pref    = '0;
        cfg_timeout = '0;
        cfg_mask    = '0;
        cfg_limit   = ERR_LIMIT_RESET;

        // nothing stored yet: neutral frame, board key masked off
        add_word(ROW_FIXED,
            misf_in_t'{CMD_REFRESH, 4'd0, 32'd0, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b1},
            misf_out_t'{4'd0, 64'd0, 16'd0, SW_NEUTRAL, 48'd0, 16'd0, 16'd0,
                        1'b0, 1'b0});
        // bad source indexes
        add_word(ROW_DROPPED,
            misf_in_t'{CMD_STORE, 4'd0, 32'd100, CH_MAX, 16'h7fff, 16'h0101, MS_MAX,
                       16'hffff, 16'hffff, 1'b1}, NO_FRAME);
        add_word(ROW_DROPPED,
            misf_in_t'{CMD_STORE, 4'd5, 32'd100, CH_MAX, 16'h7fff, 16'h0101, MS_MAX,
                       16'hffff, 16'hffff, 1'b1}, NO_FRAME);
        add_word(ROW_DROPPED,
            misf_in_t'{CMD_STORE, 4'd15, 32'd100, CH_MIN, 16'h8000, 16'h0000, MS_MIN,
                       16'hffff, 16'hffff, 1'b0}, NO_FRAME);
        // most negative values, zero switches sanitised to down
        add_word(ROW_FIXED,
            misf_in_t'{CMD_STORE, 4'd1, 32'd100, CH_MIN, 16'h8000, 16'h0000, MS_MIN,
                       16'hffff, 16'hffff, 1'b0},
            misf_out_t'{4'd1, CH_MIN, 16'h8000, SW_NEUTRAL, MS_MIN, 16'hffff,
                        16'hffff, 1'b1, 1'b1});
        // same stamp as source 1: tie goes to the lower index
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_STORE, 4'd2, 32'd100, CH_MAX, 16'h7fff, 16'h0301, MS_MAX,
                       16'h00ff, 16'h0f0f, 1'b0}, NO_FRAME);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_STORE, 4'd3, 32'd200, 64'h0001_fffe_02d4_fd2c, 16'h0005,
                       16'h0203, 48'h0001_ffff_0000, 16'h0100, 16'h8001, 1'b0},
            NO_FRAME);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_STORE, 4'd4, 32'd150, 64'h02d5_0000_ffff_0001, 16'hfff0,
                       16'hff04, 48'h1234_8001_7ffe, 16'h0000, 16'h0000, 1'b1},
            NO_FRAME);
        add_reg(CFG_MIX_MODE, 32'd1);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_REFRESH, 4'd7, 32'd300, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b0}, NO_FRAME);
        add_reg(CFG_BOARD_MASK, 32'h0000_ffff);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_REFRESH, 4'd9, 32'd300, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b1}, NO_FRAME);
        add_reg(CFG_TIMEOUT, 32'd60);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_REFRESH, 4'd0, 32'd250, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b0}, NO_FRAME);
        // everything timed out: neutral frame plus the board key mask
        add_word(ROW_FIXED,
            misf_in_t'{CMD_REFRESH, 4'd0, 32'd1000, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b1},
            misf_out_t'{4'd0, 64'd0, 16'd0, SW_NEUTRAL, 48'd0, 16'd0, 16'hffff,
                        1'b0, 1'b1});
        // preferred source timed out: falls back to the newest
        add_reg(CFG_MIX_MODE, 32'd0);
        add_reg(CFG_PREF_SRC, 32'd4);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_REFRESH, 4'd4, 32'd250, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b0}, NO_FRAME);
        add_reg(CFG_TIMEOUT, 32'hffff_ffff);
        add_reg(CFG_PREF_SRC, 32'd15);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_REFRESH, 4'd15, 32'd300, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b0}, NO_FRAME);
        add_reg(CFG_PREF_SRC, 32'd2);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_REFRESH, 4'd0, 32'd300, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b1}, NO_FRAME);
        // all stamped at 5000, fused at 4999: every age is the largest possible
        add_reg(CFG_TIMEOUT, 32'd0);
        add_reg(CFG_PREF_SRC, 32'd0);
        add_reg(CFG_MIX_MODE, 32'd1);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_STORE, 4'd1, 32'd5000, CH_MIN, 16'h8000, 16'h0102, MS_MIN,
                       16'h0001, 16'h0001, 1'b0}, NO_FRAME);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_STORE, 4'd2, 32'd5000, CH_MAX, 16'h7fff, 16'h0300, MS_MAX,
                       16'h0200, 16'h4000, 1'b1}, NO_FRAME);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_STORE, 4'd3, 32'd5000, 64'h8001_7fff_0000_ffff, 16'h0001,
                       16'h04ff, 48'h7fff_8001_0002, 16'h8000, 16'h0010, 1'b0},
            NO_FRAME);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_STORE, 4'd4, 32'd5000, 64'h0123_fedc_8000_7fff, 16'hffff,
                       16'h0303, 48'hffff_0000_8000, 16'h0040, 16'h0800, 1'b1},
            NO_FRAME);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_REFRESH, 4'd0, 32'd4999, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b0}, NO_FRAME);
        add_reg(CFG_ERR_LIMIT, 32'd0);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_REFRESH, 4'd0, 32'd4999, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b0}, NO_FRAME);
        add_reg(CFG_ERR_LIMIT, 32'd32767);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_REFRESH, 4'd0, 32'd4999, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b0}, NO_FRAME);
        add_reg(CFG_BOARD_MASK, 32'd0);
        add_word(ROW_PREDICT,
            misf_in_t'{CMD_REFRESH, 4'd0, 32'd5001, 64'd0, 16'd0, 16'd0, 48'd0,
                       16'd0, 16'd0, 1'b1}, NO_FRAME);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill[i])
        begin
            if (drill[i].kind == ROW_REG)
            begin
                settle();
                write_reg(drill[i].reg_idx, drill[i].reg_val);
            end
            else
            begin
                send_word(drill[i].word, drill[i].kind, drill[i].frame, produced);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case ($urandom_range(0, 3))
                0:       tmo = 32'd0;
                1:       tmo = 32'hffff_ffff;
                2:       tmo = $urandom_range(1, 64);
                default: tmo = $urandom_range(65, 2000);
            endcase
            case ($urandom_range(0, 2))
                0:       mask = 32'd0;
                1:       mask = 32'h0000_ffff;
                default: mask = 32'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       lim = 32'd0;
                1:       lim = 32'd32767;
                2:       lim = 32'(ERR_LIMIT_RESET);
                default: lim = $urandom_range(0, 32767);
            endcase
            write_reg(CFG_MIX_MODE, $urandom_range(0, 1));
            write_reg(CFG_PREF_SRC, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15));
            write_reg(CFG_TIMEOUT, tmo);
            write_reg(CFG_BOARD_MASK, mask);
            write_reg(CFG_ERR_LIMIT, lim);

            hold_phase = (p == 1);
            made = 0;
            while (made < PHASE_FRAMES)
            begin
                send_word(random_word(), ROW_PREDICT, NO_FRAME, produced);
                if (produced)
                    made++;
            end
            hold_phase = 1'b0;
        end

        settle();

        $display("Checked %0d frames from %0d words, %0d dropped for a bad source index",
                 frames_checked, words_sent, words_dropped);
        $display("Select and merge fusion over %0d register settings, one %0d-cycle hold-off",
                 PHASES, HOLD_CYCLES);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
